// ----- src/assert_macros.svh -----
// Assertion macros used by the arbiter back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

// ----- src/rnea_pkg.sv -----
// Types and constants of the ring neighbor exclusion arbiter.
`default_nettype none
package rnea_pkg;

    localparam int ACT_W      = 2;
    localparam int AGENT_W    = 3;
    localparam int KIND_W     = 2;
    localparam int SESS_W     = 16;
    localparam int ACK_W      = 7;
    localparam int OP_W       = 2;

    // up to three results per beat: two grants and a stop broadcast
    localparam int MAX_RESULTS = 3;
    localparam int SLOT_IW     = $clog2(MAX_RESULTS);

    localparam int QUEUE_DEPTH = 2;

    // input action codes
    localparam logic [ACT_W-1:0] ACT_REQ = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REL = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ACK = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_GRANT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STOP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HALT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd3;

    // classified operations handed from front to back
    localparam logic [OP_W-1:0] OP_REQ = 2'd0;
    localparam logic [OP_W-1:0] OP_REL = 2'd1;
    localparam logic [OP_W-1:0] OP_ACK = 2'd2;
    localparam logic [OP_W-1:0] OP_BAD = 2'd3;

    localparam logic [ACK_W-1:0] ACK_MAX = 7'd127;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [AGENT_W-1:0] agent;
    } q_entry_t;

endpackage
`default_nettype wire

// ----- src/rnea_front.sv -----
// Front end: accepts command beats and classifies them into operations.
`default_nettype none
module rnea_front #(
    parameter int PHILO_COUNT = 5
) (
    input  wire logic                        start,
    input  wire logic                        busy,
    input  wire logic [rnea_pkg::ACT_W-1:0]  action,
    input  wire logic [rnea_pkg::AGENT_W-1:0] agent_index,
    output logic                             push,
    output rnea_pkg::q_entry_t               push_entry
);
    import rnea_pkg::*;

    logic in_range;
    logic known;

    assign in_range = 32'(agent_index) < PHILO_COUNT;

    // decode action; unused codes are dropped here
    always_comb
    begin
        known            = 1'b1;
        push_entry.agent = agent_index;
        unique case (action)
            ACT_REQ: push_entry.op = in_range ? OP_REQ : OP_BAD;
            ACT_REL: push_entry.op = in_range ? OP_REL : OP_BAD;
            ACT_ACK: push_entry.op = OP_ACK;
            default:
            begin
                push_entry.op = OP_ACK;
                known         = 1'b0;
            end
        endcase
    end

    assign push = start && !busy && known;

endmodule
`default_nettype wire

// ----- src/rnea_queue.sv -----
// Short operation queue between front and back.
`default_nettype none
module rnea_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire rnea_pkg::q_entry_t push_entry,
    input  wire logic               pop,
    output logic                    full,
    output logic                    head_valid,
    output rnea_pkg::q_entry_t      head_entry
);
    import rnea_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    q_entry_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = count_reg == CNT_FULL;
    assign head_valid = count_reg != '0;
    assign head_entry = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

// ----- src/rnea_back.sv -----
// Back end: agent ring state, session counting and result sequencing.
`default_nettype none
`include "assert_macros.svh"
module rnea_back #(
    parameter int PHILO_COUNT = 5
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire rnea_pkg::q_entry_t            q_entry,
    output logic                               q_pop,
    input  wire logic                          cfg_valid,
    input  wire logic [rnea_pkg::SESS_W-1:0]   session_limit,
    output logic                               result_strobe,
    output logic [rnea_pkg::KIND_W-1:0]        result_kind,
    output logic [rnea_pkg::AGENT_W-1:0]       granted_agent,
    output logic                               last
);
    import rnea_pkg::*;

    localparam int IDX_W = $clog2(PHILO_COUNT);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PHILO_COUNT - 1);
    localparam logic [ACK_W-1:0] ACK_HALT = ACK_W'(PHILO_COUNT);
    localparam logic [PHILO_COUNT-1:0] ONE = {{(PHILO_COUNT-1){1'b0}}, 1'b1};

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    function automatic logic [IDX_W-1:0] left_of(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_LAST : i - 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] right_of(input logic [IDX_W-1:0] i);
        return (i == IDX_LAST) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [SESS_W-1:0] dec_sat(input logic [SESS_W-1:0] v);
        return (v != '0) ? v - 1'b1 : v;
    endfunction

    logic                   state_reg, state_next;
    logic [PHILO_COUNT-1:0] hold_reg, hold_next;
    logic [PHILO_COUNT-1:0] wait_reg, wait_next;
    logic [SESS_W-1:0]      sess_reg, sess_next;
    logic                   stopping_reg, stopping_next;
    logic [ACK_W-1:0]       acks_reg, acks_next;
    logic [KIND_W-1:0]      slot_kind_reg [MAX_RESULTS];
    logic [KIND_W-1:0]      slot_kind_next [MAX_RESULTS];
    logic [AGENT_W-1:0]     slot_agent_reg [MAX_RESULTS];
    logic [AGENT_W-1:0]     slot_agent_next [MAX_RESULTS];
    logic [MAX_RESULTS-1:0] slot_vld_reg, slot_vld_next;
    logic                   strobe_reg, strobe_next;
    logic [KIND_W-1:0]      kind_reg, kind_next;
    logic [AGENT_W-1:0]     agent_reg, agent_next;
    logic                   last_reg, last_next;

    logic [IDX_W-1:0]       a, l, r;
    logic [PHILO_COUNT-1:0] oh_a, oh_l, oh_r;
    logic [PHILO_COUNT-1:0] hold0, hold1, hold_rot;
    logic                   serv_a, gl, gr;
    logic [SESS_W-1:0]      sess_req, sess_l, sess_r;
    logic [ACK_W-1:0]       acks_inc;

    // operand decode and neighbor checks
    assign a      = IDX_W'(q_entry.agent);
    assign l      = left_of(a);
    assign r      = right_of(a);
    assign oh_a   = ONE << a;
    assign oh_l   = ONE << l;
    assign oh_r   = ONE << r;
    assign serv_a = !hold_reg[l] && !hold_reg[r];

    // release: free the agent, then try left, then right neighbor
    assign hold0  = hold_reg & ~oh_a;
    assign gl     = wait_reg[l] && !hold0[left_of(l)] && !hold0[right_of(l)];
    assign hold1  = gl ? (hold0 | oh_l) : hold0;
    assign gr     = wait_reg[r] && !hold1[left_of(r)] && !hold1[right_of(r)];

    assign sess_req = dec_sat(sess_reg);
    assign sess_l   = gl ? dec_sat(sess_reg) : sess_reg;
    assign sess_r   = gr ? dec_sat(sess_l) : sess_l;

    assign acks_inc = (acks_reg < ACK_MAX) ? acks_reg + 1'b1 : acks_reg;

    assign hold_rot = {hold_reg[PHILO_COUNT-2:0], hold_reg[PHILO_COUNT-1]};

    // execute one operation into the result slots, then shift them out
    always_comb
    begin
        logic [SLOT_IW-1:0] p;

        state_next    = state_reg;
        hold_next     = hold_reg;
        wait_next     = wait_reg;
        sess_next     = sess_reg;
        stopping_next = stopping_reg;
        acks_next     = acks_reg;
        slot_vld_next = slot_vld_reg;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            slot_kind_next[i]  = slot_kind_reg[i];
            slot_agent_next[i] = slot_agent_reg[i];
        end
        strobe_next = 1'b0;
        kind_next   = kind_reg;
        agent_next  = agent_reg;
        last_next   = last_reg;
        q_pop       = 1'b0;
        p           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop         = 1'b1;
                    slot_vld_next = '0;
                    for (int i = 0; i < MAX_RESULTS; i++)
                    begin
                        slot_kind_next[i]  = KIND_GRANT;
                        slot_agent_next[i] = '0;
                    end
                    if (stopping_reg)
                    begin
                        if (q_entry.op == OP_ACK)
                        begin
                            acks_next = acks_inc;
                            if (acks_inc == ACK_HALT)
                            begin
                                slot_kind_next[0] = KIND_HALT;
                                slot_vld_next[0]  = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        unique case (q_entry.op)
                            OP_BAD:
                            begin
                                slot_kind_next[0] = KIND_ERROR;
                                slot_vld_next[0]  = 1'b1;
                            end
                            OP_REQ:
                            begin
                                if (wait_reg[a])
                                begin
                                    slot_kind_next[0] = KIND_ERROR;
                                    slot_vld_next[0]  = 1'b1;
                                end
                                else if (serv_a)
                                begin
                                    hold_next          = hold_reg | oh_a;
                                    wait_next          = wait_reg & ~oh_a;
                                    sess_next          = sess_req;
                                    slot_kind_next[0]  = KIND_GRANT;
                                    slot_agent_next[0] = AGENT_W'(a);
                                    slot_vld_next[0]   = 1'b1;
                                    if (sess_req == '0)
                                    begin
                                        slot_kind_next[1] = KIND_STOP;
                                        slot_vld_next[1]  = 1'b1;
                                        stopping_next     = 1'b1;
                                    end
                                end
                                else
                                begin
                                    hold_next = hold_reg & ~oh_a;
                                    wait_next = wait_reg | oh_a;
                                end
                            end
                            OP_REL:
                            begin
                                if (!hold_reg[a])
                                begin
                                    slot_kind_next[0] = KIND_ERROR;
                                    slot_vld_next[0]  = 1'b1;
                                end
                                else
                                begin
                                    hold_next = gr ? (hold1 | oh_r) : hold1;
                                    wait_next = wait_reg & ~(gl ? oh_l : '0)
                                                         & ~(gr ? oh_r : '0);
                                    sess_next = sess_r;
                                    if (gl)
                                    begin
                                        slot_kind_next[p]  = KIND_GRANT;
                                        slot_agent_next[p] = AGENT_W'(l);
                                        slot_vld_next[p]   = 1'b1;
                                        p                  = p + 1'b1;
                                    end
                                    if (gr)
                                    begin
                                        slot_kind_next[p]  = KIND_GRANT;
                                        slot_agent_next[p] = AGENT_W'(r);
                                        slot_vld_next[p]   = 1'b1;
                                        p                  = p + 1'b1;
                                    end
                                    if (sess_r == '0)
                                    begin
                                        slot_kind_next[p] = KIND_STOP;
                                        slot_vld_next[p]  = 1'b1;
                                        stopping_next     = 1'b1;
                                    end
                                end
                            end
                            default:
                            begin
                                // acknowledgement while serving: ignored
                            end
                        endcase
                    end
                    if (slot_vld_next[0])
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                strobe_next = 1'b1;
                kind_next   = slot_kind_reg[0];
                agent_next  = slot_agent_reg[0];
                last_next   = !slot_vld_reg[1];
                for (int i = 0; i < MAX_RESULTS - 1; i++)
                begin
                    slot_kind_next[i]  = slot_kind_reg[i+1];
                    slot_agent_next[i] = slot_agent_reg[i+1];
                end
                slot_vld_next = {1'b0, slot_vld_reg[MAX_RESULTS-1:1]};
                if (!slot_vld_reg[1])
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // register write reloads the session counter
        if (cfg_valid)
        begin
            sess_next = session_limit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            hold_reg     <= '0;
            wait_reg     <= '0;
            sess_reg     <= '0;
            stopping_reg <= 1'b0;
            acks_reg     <= '0;
            slot_vld_reg <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            hold_reg     <= hold_next;
            wait_reg     <= wait_next;
            sess_reg     <= sess_next;
            stopping_reg <= stopping_next;
            acks_reg     <= acks_next;
            slot_vld_reg <= slot_vld_next;
            strobe_reg   <= strobe_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            slot_kind_reg[i]  <= slot_kind_next[i];
            slot_agent_reg[i] <= slot_agent_next[i];
        end
        kind_reg  <= kind_next;
        agent_reg <= agent_next;
        last_reg  <= last_next;
    end

    assign result_strobe = strobe_reg;
    assign result_kind   = kind_reg;
    assign granted_agent = agent_reg;
    assign last          = last_reg;

    `ASSERT_NEVER(a_hold_wait_excl, clk, rst_n, |(hold_reg & wait_reg))
    `ASSERT_NEVER(a_neighbors_hold, clk, rst_n, |(hold_reg & hold_rot))
    `ASSERT_ALWAYS(a_last_ends_seq, clk, rst_n, strobe_reg && last_reg |-> state_reg == ST_IDLE)
    `ASSERT_ALWAYS(a_slots_packed, clk, rst_n, slot_vld_reg[2] |-> slot_vld_reg[1])

endmodule
`default_nettype wire

// ----- src/ring_neighbor_exclusion_arbiter.sv -----
// The first result passes the queue, the result slots and the output register
// before it strobes. The back end takes an item only while idle and emits its
// results (0 to 3) one per cycle; a two-entry queue takes commands meanwhile.
// busy is high while that queue is full; results cannot be stalled.
// Reset clears all agents to idle, sessions to 0, stopping mode and ack count.
`default_nettype none
module ring_neighbor_exclusion_arbiter #(
    parameter int PHILO_COUNT = 5
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [rnea_pkg::ACT_W-1:0]    action,
    input  wire logic [rnea_pkg::AGENT_W-1:0]  agent_index,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rnea_pkg::SESS_W-1:0]   session_limit,
    output logic                               result_strobe,
    output logic [rnea_pkg::KIND_W-1:0]        result_kind,
    output logic [rnea_pkg::AGENT_W-1:0]       granted_agent,
    output logic                               last
);
    import rnea_pkg::*;

    logic     push;
    q_entry_t push_entry;
    logic     q_full;
    logic     q_valid;
    q_entry_t q_entry;
    logic     q_pop;

    // register writes take effect at once
    assign cfg_ready = 1'b1;
    assign busy      = q_full;

    rnea_front #(
        .PHILO_COUNT (PHILO_COUNT)
    ) u_front (
        .start       (start),
        .busy        (q_full),
        .action      (action),
        .agent_index (agent_index),
        .push        (push),
        .push_entry  (push_entry)
    );

    rnea_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_entry (q_entry)
    );

    rnea_back #(
        .PHILO_COUNT (PHILO_COUNT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_pop         (q_pop),
        .cfg_valid     (cfg_valid),
        .session_limit (session_limit),
        .result_strobe (result_strobe),
        .result_kind   (result_kind),
        .granted_agent (granted_agent),
        .last          (last)
    );

endmodule
`default_nettype wire

// ----- test/ring_neighbor_exclusion_arbiter_tb.sv -----
// Testbench for the ring neighbor exclusion arbiter: directed and random commands, scoreboard.
`timescale 1ns / 100ps
module ring_neighbor_exclusion_arbiter_tb;
    import rnea_pkg::*;

    localparam int N = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef enum logic [1:0] {SEAT_IDLE, SEAT_WAITING, SEAT_HOLDING} seat_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [AGENT_W-1:0] agent;
        logic               last;
    } result_t;

    // Tracks the ring table and the results each command must produce
    class grant_board;
        seat_t             seats [N];
        logic [SESS_W-1:0] sessions_left;
        bit                stopping;
        logic [ACK_W-1:0]  acks;
        result_t           due_results [$];
        result_t           fresh [MAX_RESULTS];
        int                n_fresh;
        int                mismatches;

        function new();
            foreach (seats[i]) seats[i] = SEAT_IDLE;
            sessions_left = '0;
            stopping = 0;
            acks = '0;
            mismatches = 0;
        endfunction

        function void set_limit(logic [SESS_W-1:0] v);
            sessions_left = v;
        endfunction

        function int left_of(int a);
            return (a == 0) ? N - 1 : a - 1;
        endfunction

        function int right_of(int a);
            return (a == N - 1) ? 0 : a + 1;
        endfunction

        function bit servable(int a);
            return seats[left_of(a)] != SEAT_HOLDING && seats[right_of(a)] != SEAT_HOLDING;
        endfunction

        function void add_result(logic [KIND_W-1:0] kind, logic [AGENT_W-1:0] agent);
            fresh[n_fresh] = '{kind: kind, agent: agent, last: 1'b0};
            n_fresh++;
        endfunction

        function void grant_to(int a);
            seats[a] = SEAT_HOLDING;
            if (sessions_left != 0)
                sessions_left = sessions_left - 1'b1;
            add_result(KIND_GRANT, a[AGENT_W-1:0]);
        endfunction

        function void stop_if_spent();
            if (sessions_left == 0)
            begin
                add_result(KIND_STOP, '0);
                stopping = 1;
            end
        endfunction

        // returns a random holding agent, or -1 when nobody holds
        function int pick_holder();
            int holders [$];
            foreach (seats[i])
                if (seats[i] == SEAT_HOLDING)
                    holders.push_back(i);
            if (holders.size() == 0)
                return -1;
            return holders[$urandom_range(0, holders.size() - 1)];
        endfunction

        // Called for every accepted command beat
        function void take_command(logic [ACT_W-1:0] act, logic [AGENT_W-1:0] idx);
            int a;
            n_fresh = 0;
            a = int'(idx);
            if (stopping)
            begin
                if (act == ACT_ACK)
                begin
                    if (acks < ACK_MAX)
                        acks = acks + 1'b1;
                    if (acks == N)
                        add_result(KIND_HALT, '0);
                end
            end
            else if (act == ACT_REQ || act == ACT_REL)
            begin
                if (a >= N)
                    add_result(KIND_ERROR, '0);
                else if (act == ACT_REQ)
                begin
                    if (seats[a] == SEAT_WAITING)
                        add_result(KIND_ERROR, '0);
                    else if (servable(a))
                    begin
                        grant_to(a);
                        stop_if_spent();
                    end
                    else
                        seats[a] = SEAT_WAITING;
                end
                else if (seats[a] != SEAT_HOLDING)
                    add_result(KIND_ERROR, '0);
                else
                begin
                    // freed seat: left neighbor first, then right
                    seats[a] = SEAT_IDLE;
                    if (seats[left_of(a)] == SEAT_WAITING && servable(left_of(a)))
                        grant_to(left_of(a));
                    if (seats[right_of(a)] == SEAT_WAITING && servable(right_of(a)))
                        grant_to(right_of(a));
                    stop_if_spent();
                end
            end
            for (int i = 0; i < n_fresh; i++)
            begin
                fresh[i].last = (i == n_fresh - 1);
                due_results.push_back(fresh[i]);
            end
        endfunction

        // Called for every result strobe
        function void check_result(logic [KIND_W-1:0] kind, logic [AGENT_W-1:0] agent,
                                   logic lst);
            result_t want;
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d agent %0d last %0d",
                             kind, agent, lst);
                return;
            end
            want = due_results.pop_front();
            if (want.kind !== kind || want.agent !== agent || want.last !== lst)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result mismatch: expected kind %0d agent %0d last %0d",
                             want.kind, want.agent, want.last);
                    $display("                 got kind %0d agent %0d last %0d",
                             kind, agent, lst);
                end
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [ACT_W-1:0]    action;
    logic [AGENT_W-1:0]  agent_index;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [SESS_W-1:0]   session_limit;
    logic                result_strobe;
    logic [KIND_W-1:0]   result_kind;
    logic [AGENT_W-1:0]  granted_agent;
    logic                last;

    grant_board board = new();
    int cycles = 0;

    ring_neighbor_exclusion_arbiter #(.PHILO_COUNT(N)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .agent_index   (agent_index),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .session_limit (session_limit),
        .result_strobe (result_strobe),
        .result_kind   (result_kind),
        .granted_agent (granted_agent),
        .last          (last)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
            board.check_result(result_kind, granted_agent, last);
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // One command beat; entered and left at a falling edge, start stays high
    task automatic send_command(logic [ACT_W-1:0] act, logic [AGENT_W-1:0] idx);
        start = 1'b1;
        action = act;
        agent_index = idx;
        do
            @(posedge clk);
        while (busy);
        board.take_command(act, idx);
        @(negedge clk);
    endtask

    // each cycle idles with the given chance in a hundred
    task automatic sender_pause(int pct);
        while ($urandom_range(0, 99) < pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
    endtask

    // Drain all due results, then let commands without results work through
    task automatic settle();
        start = 1'b0;
        while (board.due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_session_limit(logic [SESS_W-1:0] v);
        cfg_valid = 1'b1;
        session_limit = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_limit(v);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Mostly well-formed traffic: requests and releases by holders, some noise
    task automatic pick_command(output logic [ACT_W-1:0] act, output logic [AGENT_W-1:0] idx);
        int r;
        int h;
        r = $urandom_range(0, 99);
        idx = AGENT_W'($urandom_range(0, N - 1));
        if (board.stopping)
        begin
            if (r < 85)
            begin
                act = ACT_ACK;
                idx = AGENT_W'($urandom_range(0, 7));
            end
            else if (r < 92)
                act = ACT_REQ;
            else if (r < 96)
                act = ACT_REL;
            else
                act = ACT_UNUSED;
        end
        else if (r < 45)
            act = ACT_REQ;
        else if (r < 83)
        begin
            act = ACT_REL;
            h = board.pick_holder();
            if (h >= 0)
                idx = AGENT_W'(h);
        end
        else if (r < 89)
        begin
            act = $urandom_range(0, 1) ? ACT_REQ : ACT_REL;
            idx = AGENT_W'($urandom_range(N, 7));
        end
        else if (r < 94)
            act = ACT_REL;
        else if (r < 97)
            act = ACT_ACK;
        else
        begin
            act = ACT_UNUSED;
            idx = AGENT_W'($urandom_range(0, 7));
        end
    endtask

    task automatic run_random(int count, int idle_pct);
        logic [ACT_W-1:0]   act;
        logic [AGENT_W-1:0] idx;
        repeat (count)
        begin
            pick_command(act, idx);
            sender_pause(idle_pct);
            send_command(act, idx);
        end
        start = 1'b0;
    endtask

    initial
    begin
        logic [ACT_W-1:0]   act;
        logic [AGENT_W-1:0] idx;
        int extra;
        rst_n = 1'b0;
        start = 1'b0;
        action = '0;
        agent_index = '0;
        cfg_valid = 1'b0;
        session_limit = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (SETTLE_CYCLES) @(negedge clk);

        // zero limit: only commands that cannot grant
        write_session_limit('0);
        send_command(ACT_REL, 3'd0);     // release while idle
        send_command(ACT_REQ, 3'd5);     // index out of range
        send_command(ACT_REQ, 3'd7);
        send_command(ACT_REL, 3'd6);
        send_command(ACT_UNUSED, 3'd2);  // unused action code
        send_command(ACT_ACK, 3'd4);     // ack while serving
        settle();

        // widest limit: grants, waits, double grant on one release
        write_session_limit(16'hFFFF);
        send_command(ACT_REQ, 3'd0);
        send_command(ACT_REQ, 3'd1);     // neighbor holds: waits
        send_command(ACT_REQ, 3'd1);     // request while waiting
        send_command(ACT_REQ, 3'd0);     // request while holding
        send_command(ACT_REQ, 3'd4);
        send_command(ACT_REL, 3'd0);     // serves left then right
        send_command(ACT_REL, 3'd3);     // release by non-holder
        send_command(ACT_REL, 3'd4);     // nobody waiting
        send_command(ACT_REQ, 3'd2);
        send_command(ACT_REL, 3'd1);     // serves right neighbor only
        send_command(ACT_REL, 3'd7);
        send_command(ACT_UNUSED, 3'd7);
        send_command(ACT_REL, 3'd2);
        start = 1'b0;

        run_random(90, 11);
        settle();
        write_session_limit(SESS_W'($urandom_range(1, 16'hFFFE)));
        run_random(90, 72);
        settle();

        // short limit: run into the stop broadcast, then acks past saturation
        write_session_limit(SESS_W'($urandom_range(0, 1) ? 0 : $urandom_range(1, 3)));
        extra = 0;
        for (int k = 0; k < 400 && extra < 10; k++)
        begin
            pick_command(act, idx);
            send_command(act, idx);
            if (board.acks == ACK_MAX)
                extra++;
        end
        start = 1'b0;

        while (board.due_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.mismatches == 0 && board.due_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+src
src/rnea_pkg.sv
src/rnea_front.sv
src/rnea_queue.sv
src/rnea_back.sv
src/ring_neighbor_exclusion_arbiter.sv
test/ring_neighbor_exclusion_arbiter_tb.sv
